// ----- hw/rtl/pft_pkg.sv -----
`default_nettype none
package pft_pkg;
	localparam int CoordW = 32;
	localparam int EdgeW = 33;
	localparam int UnitW = 32;
	localparam int OffW = 48;
	localparam int ProdW = 66;
	localparam int NormW = 67;
	localparam int SumW = 132;
	localparam int QBits = 31;
	localparam int HalfW = 33;

	typedef struct packed {
		logic signed [CoordW-1:0] first_x;
		logic signed [CoordW-1:0] first_y;
		logic signed [CoordW-1:0] first_z;
		logic signed [CoordW-1:0] second_x;
		logic signed [CoordW-1:0] second_y;
		logic signed [CoordW-1:0] second_z;
		logic signed [CoordW-1:0] third_x;
		logic signed [CoordW-1:0] third_y;
		logic signed [CoordW-1:0] third_z;
	} tri_t;

	typedef struct packed {
		logic signed [UnitW-1:0] unit_nx;
		logic signed [UnitW-1:0] unit_ny;
		logic signed [UnitW-1:0] unit_nz;
		logic signed [OffW-1:0]  plane_offset;
		logic                    degenerate;
	} plane_t;
endpackage
`default_nettype wire

// ----- hw/rtl/pft_stream_if.sv -----
`default_nettype none
interface pft_stream_if #(parameter type payload_t = logic);
	logic     valid;
	logic     ready;
	payload_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ----- hw/rtl/plane_from_triangle_top.sv -----
// Depth: a result passes through every pipeline stage before it is valid at the output;
// the 31 quotient bit stages set most of the depth.
// Throughput: one triangle per cycle; a stall freezes the whole pipeline.
// Each quotient bit stage updates a running remainder with shifts and adds only.
// Reset clears the valid bits of every stage; payload registers are not reset.
`default_nettype none
module plane_from_triangle_top (
	input  wire logic clk,
	input  wire logic arst_n,
	pft_stream_if.sink   tri_in,
	pft_stream_if.source plane_out
);
	localparam int NSt = 40;
	localparam int QS = 6;
	localparam int LimW = pft_pkg::SumW + 60;
	localparam int RemW = LimW + 4;
	localparam int QsW = pft_pkg::SumW + pft_pkg::QBits;

	logic [NSt-1:0] vld_q;
	logic adv;
	assign adv = !vld_q[NSt-1] || plane_out.ready;
	assign tri_in.ready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (adv) begin
			vld_q <= {vld_q[NSt-2:0], tri_in.valid};
		end
	end

	logic signed [pft_pkg::CoordW-1:0] p_s [NSt][3];
	logic signed [pft_pkg::EdgeW-1:0] e1_s1 [3];
	logic signed [pft_pkg::EdgeW-1:0] e2_s1 [3];
	logic signed [pft_pkg::ProdW-1:0] pa_s2 [3];
	logic signed [pft_pkg::ProdW-1:0] pb_s2 [3];
	logic [pft_pkg::NormW-1:0] nmag_s [NSt][3];
	logic nneg_s [NSt][3];
	logic [pft_pkg::ProdW-1:0] hh_s4 [3];
	logic [pft_pkg::ProdW-1:0] hl_s4 [3];
	logic [pft_pkg::ProdW-1:0] ll_s4 [3];
	logic [pft_pkg::SumW-1:0] sq_s5 [3];
	logic [pft_pkg::SumW-1:0] s_s [NSt];
	logic [LimW-1:0] rem_s [NSt][3];
	logic [QsW-1:0] qs_s [NSt][3];
	logic [pft_pkg::QBits-1:0] q_s [NSt][3];
	logic degen_s [NSt];
	logic signed [pft_pkg::UnitW-1:0] u_s [NSt][3];
	logic signed [64:0] dp_s [3];
	logic signed [66:0] dot_s;
	pft_pkg::plane_t res_s;

	always_ff @(posedge clk) begin
		if (adv) begin
			p_s[0][0] <= tri_in.data.first_x;
			p_s[0][1] <= tri_in.data.first_y;
			p_s[0][2] <= tri_in.data.first_z;
			e1_s1[0] <= 33'(tri_in.data.second_x) - 33'(tri_in.data.first_x);
			e1_s1[1] <= 33'(tri_in.data.second_y) - 33'(tri_in.data.first_y);
			e1_s1[2] <= 33'(tri_in.data.second_z) - 33'(tri_in.data.first_z);
			e2_s1[0] <= 33'(tri_in.data.third_x) - 33'(tri_in.data.first_x);
			e2_s1[1] <= 33'(tri_in.data.third_y) - 33'(tri_in.data.first_y);
			e2_s1[2] <= 33'(tri_in.data.third_z) - 33'(tri_in.data.first_z);
			for (int i = 1; i < NSt; i++) begin
				p_s[i] <= p_s[i-1];
			end
			pa_s2[0] <= e1_s1[1] * e2_s1[2];
			pb_s2[0] <= e1_s1[2] * e2_s1[1];
			pa_s2[1] <= e1_s1[2] * e2_s1[0];
			pb_s2[1] <= e1_s1[0] * e2_s1[2];
			pa_s2[2] <= e1_s1[0] * e2_s1[1];
			pb_s2[2] <= e1_s1[1] * e2_s1[0];
			for (int i = 0; i < 3; i++) begin
				logic signed [pft_pkg::NormW-1:0] n;
				logic [pft_pkg::HalfW-1:0] hi;
				logic [pft_pkg::HalfW-1:0] lo;
				n = 67'(pa_s2[i]) - 67'(pb_s2[i]);
				nneg_s[2][i] <= n[pft_pkg::NormW-1];
				nmag_s[2][i] <= n[pft_pkg::NormW-1] ? 67'(-n) : 67'(n);
				hi = nmag_s[2][i][2*pft_pkg::HalfW-1:pft_pkg::HalfW];
				lo = nmag_s[2][i][pft_pkg::HalfW-1:0];
				hh_s4[i] <= hi * hi;
				hl_s4[i] <= hi * lo;
				ll_s4[i] <= lo * lo;
				nneg_s[3][i] <= nneg_s[2][i];
				sq_s5[i] <= (132'(hh_s4[i]) << (2 * pft_pkg::HalfW))
					+ (132'(hl_s4[i]) << (pft_pkg::HalfW + 1)) + 132'(ll_s4[i]);
				nneg_s[4][i] <= nneg_s[3][i];
				rem_s[5][i] <= 192'(sq_s5[i]) << 60;
				qs_s[5][i] <= '0;
				q_s[5][i] <= '0;
				nneg_s[5][i] <= nneg_s[4][i];
			end
			degen_s[3] <= (nmag_s[2][0] == '0) && (nmag_s[2][1] == '0)
				&& (nmag_s[2][2] == '0);
			degen_s[4] <= degen_s[3];
			s_s[5] <= sq_s5[0] + sq_s5[1] + sq_s5[2];
			degen_s[5] <= degen_s[4];
			for (int k = 0; k < pft_pkg::QBits; k++) begin
				s_s[QS+k] <= s_s[QS+k-1];
				degen_s[QS+k] <= degen_s[QS+k-1];
				for (int i = 0; i < 3; i++) begin
					logic [RemW-1:0] d;
					d = 196'(rem_s[QS+k-1][i])
						- (196'(qs_s[QS+k-1][i]) << (pft_pkg::QBits - k))
						- (196'(s_s[QS+k-1]) << (2 * (pft_pkg::QBits - 1 - k)));
					if (!d[RemW-1]) begin
						rem_s[QS+k][i] <= 192'(d);
						qs_s[QS+k][i] <= qs_s[QS+k-1][i]
							+ (163'(s_s[QS+k-1]) << (pft_pkg::QBits - 1 - k));
						q_s[QS+k][i] <= q_s[QS+k-1][i]
							| (31'(1) << (pft_pkg::QBits - 1 - k));
					end else begin
						rem_s[QS+k][i] <= rem_s[QS+k-1][i];
						qs_s[QS+k][i] <= qs_s[QS+k-1][i];
						q_s[QS+k][i] <= q_s[QS+k-1][i];
					end
					nneg_s[QS+k][i] <= nneg_s[QS+k-1][i];
				end
			end
			for (int i = 0; i < 3; i++) begin
				u_s[37][i] <= degen_s[36] ? '0 :
					(nneg_s[36][i] ? -32'(q_s[36][i]) : 32'(q_s[36][i]));
				dp_s[i] <= u_s[37][i] * p_s[37][i];
				u_s[38][i] <= u_s[37][i];
			end
			degen_s[37] <= degen_s[36];
			degen_s[38] <= degen_s[37];
			dot_s <= 67'(dp_s[0]) + 67'(dp_s[1]) + 67'(dp_s[2]);
			for (int i = 0; i < 3; i++) u_s[39][i] <= u_s[38][i];
			degen_s[39] <= degen_s[38];
		end
	end

	always_comb begin
		logic [66:0] m;
		m = dot_s[66] ? 67'(-dot_s) : 67'(dot_s);
		m = m >> 30;
		res_s.unit_nx = u_s[39][0];
		res_s.unit_ny = u_s[39][1];
		res_s.unit_nz = u_s[39][2];
		res_s.plane_offset = dot_s[66] ? 48'(m) : 48'(-m);
		res_s.degenerate = degen_s[39];
	end

	assign plane_out.valid = vld_q[NSt-1];
	assign plane_out.data = res_s;

	assert property (@(posedge clk) disable iff (!arst_n)
		plane_out.valid && !plane_out.ready |=> plane_out.valid)
		else $error("result dropped under stall");
	assert property (@(posedge clk) disable iff (!arst_n)
		plane_out.valid && plane_out.data.degenerate |->
		plane_out.data.plane_offset == '0)
		else $error("degenerate result carries offset");
	assert property (@(posedge clk) disable iff (!arst_n)
		!plane_out.ready && plane_out.valid |-> !tri_in.ready)
		else $error("input taken while pipeline stalled");
endmodule
`default_nettype wire
